[src/pmi_pkg.sv]
// ----------------------------------------------------------------------------
// pmi_pkg
// types, constants and helpers shared by the periodic minimum image unit
// ----------------------------------------------------------------------------
package pmi_pkg;

    localparam int COORD_W  = 32;
    localparam int FIELD_W  = 21;
    localparam int CFG_W    = 63;
    localparam int CFG_IDX_W = 3;
    localparam int INV_FRAC = 19;
    localparam int CELL_FRAC = 10;

    localparam int D_W      = COORD_W + 1;
    localparam int P1_W     = D_W + FIELD_W;
    localparam int ACC1_W   = P1_W + 2;
    localparam int S_W      = ACC1_W - INV_FRAC + 1;
    localparam int P2_W     = S_W + FIELD_W;
    localparam int ACC2_W   = P2_W + 2;
    localparam int BACK_W   = ACC2_W - CELL_FRAC;
    localparam int SUM_W    = BACK_W + 1;

    typedef enum logic [1:0] {
        CMD_IMAGE_POS  = 2'd0,
        CMD_IMAGE_DISP = 2'd1,
        CMD_FOLD       = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CELL_PRESENT = 3'd0,
        CFG_AXIS_A       = 3'd1,
        CFG_AXIS_B       = 3'd2,
        CFG_AXIS_C       = 3'd3,
        CFG_INV_ROW_X    = 3'd4,
        CFG_INV_ROW_Y    = 3'd5,
        CFG_INV_ROW_Z    = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        t_cmd                      command;
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic signed [COORD_W-1:0] first_z;
        logic signed [COORD_W-1:0] ref_x;
        logic signed [COORD_W-1:0] ref_y;
        logic signed [COORD_W-1:0] ref_z;
    } t_in;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
    } t_out;

    // load enables of the two register stages inside a submodule
    typedef struct packed {
        logic first;
        logic second;
    } t_adv;

    typedef logic [CFG_W-1:0] t_cfg_word;

    function automatic logic signed [FIELD_W-1:0] field21(
        input t_cfg_word word,
        input logic [1:0] k
    );
        return $signed(word[FIELD_W*k +: FIELD_W]);
    endfunction

endpackage

[src/pmi_frac.sv]
// ----------------------------------------------------------------------------
// pmi_frac
// real to fractional mapping with the inverse matrix and one unit shift
// ----------------------------------------------------------------------------
module pmi_frac #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                                  i_clk,
    input  pmi_pkg::t_adv                         i_adv,
    input  logic signed [pmi_pkg::D_W-1:0]        i_d [3],
    input  logic                                  i_fold,
    input  pmi_pkg::t_cfg_word                    i_inv [3],
    output logic signed [pmi_pkg::S_W-1:0]        o_s [3]
);

    localparam logic signed [pmi_pkg::S_W-1:0] ONE  =
        pmi_pkg::S_W'(1) << COORD_FRAC_BITS;
    localparam logic signed [pmi_pkg::S_W-1:0] HALF =
        pmi_pkg::S_W'(1) << (COORD_FRAC_BITS - 1);

    logic signed [pmi_pkg::P1_W-1:0] r_prod [3][3];
    logic                            r_fold;
    logic signed [pmi_pkg::S_W-1:0]  r_s [3];
    logic signed [pmi_pkg::S_W-1:0]  n_s [3];

    // products: component k weighted by real component j
    always_ff @(posedge i_clk) begin
        if (i_adv.first) begin
            r_fold <= i_fold;
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r_prod[k][j] <= i_d[j] * pmi_pkg::field21(i_inv[j], 2'(k));
                end
            end
        end
    end

    always_comb begin
        logic signed [pmi_pkg::ACC1_W-1:0] acc;
        logic signed [pmi_pkg::S_W-1:0]    s;
        for (int k = 0; k < 3; k++) begin
            acc = pmi_pkg::ACC1_W'(r_prod[k][0]) + pmi_pkg::ACC1_W'(r_prod[k][1])
                + pmi_pkg::ACC1_W'(r_prod[k][2]);
            s = pmi_pkg::S_W'($signed(acc[pmi_pkg::ACC1_W-1:pmi_pkg::INV_FRAC]));
            if (r_fold) begin
                if (s < 0) begin
                    s = s + ONE;
                end else if (s >= ONE) begin
                    s = s - ONE;
                end
            end else begin
                if (s < -HALF) begin
                    s = s + ONE;
                end
                if (s > HALF) begin
                    s = s - ONE;
                end
            end
            n_s[k] = s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.second) begin
            r_s <= n_s;
        end
    end

    assign o_s = r_s;

endmodule

[src/pmi_back.sv]
// ----------------------------------------------------------------------------
// pmi_back
// fractional to real with the cell vectors (else i_d), offset and saturation
// ----------------------------------------------------------------------------
module pmi_back (
    input  logic                                  i_clk,
    input  pmi_pkg::t_adv                         i_adv,
    input  logic signed [pmi_pkg::S_W-1:0]        i_s [3],
    input  pmi_pkg::t_cfg_word                    i_axis [3],
    input  logic                                  i_cell,
    input  logic signed [pmi_pkg::D_W-1:0]        i_d [3],
    input  logic signed [pmi_pkg::COORD_W-1:0]    i_add [3],
    output pmi_pkg::t_out                         o_out
);

    localparam logic signed [pmi_pkg::SUM_W-1:0] SAT_MAX =
        pmi_pkg::SUM_W'({1'b0, {(pmi_pkg::COORD_W-1){1'b1}}});
    localparam logic signed [pmi_pkg::SUM_W-1:0] SAT_MIN = -SAT_MAX - 1;

    logic signed [pmi_pkg::P2_W-1:0]    r_prod [3][3];
    logic signed [pmi_pkg::COORD_W-1:0] n_res [3];
    pmi_pkg::t_out                      r_out;

    // products: real component j from fractional component k
    always_ff @(posedge i_clk) begin
        if (i_adv.first) begin
            for (int j = 0; j < 3; j++) begin
                for (int k = 0; k < 3; k++) begin
                    r_prod[j][k] <= i_s[k] * pmi_pkg::field21(i_axis[k], 2'(j));
                end
            end
        end
    end

    always_comb begin
        logic signed [pmi_pkg::ACC2_W-1:0] acc;
        logic signed [pmi_pkg::BACK_W-1:0] vec;
        logic signed [pmi_pkg::SUM_W-1:0]  sum;
        for (int j = 0; j < 3; j++) begin
            acc = pmi_pkg::ACC2_W'(r_prod[j][0]) + pmi_pkg::ACC2_W'(r_prod[j][1])
                + pmi_pkg::ACC2_W'(r_prod[j][2]);
            if (i_cell) begin
                vec = $signed(acc[pmi_pkg::ACC2_W-1:pmi_pkg::CELL_FRAC]);
            end else begin
                vec = pmi_pkg::BACK_W'(i_d[j]);
            end
            sum = pmi_pkg::SUM_W'(vec) + pmi_pkg::SUM_W'(i_add[j]);
            if (sum > SAT_MAX) begin
                n_res[j] = SAT_MAX[pmi_pkg::COORD_W-1:0];
            end else if (sum < SAT_MIN) begin
                n_res[j] = SAT_MIN[pmi_pkg::COORD_W-1:0];
            end else begin
                n_res[j] = sum[pmi_pkg::COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.second) begin
            r_out.out_x <= n_res[0];
            r_out.out_y <= n_res[1];
            r_out.out_z <= n_res[2];
        end
    end

    assign o_out = r_out;

endmodule

[src/periodic_minimum_image_unit_core.sv]
// ----------------------------------------------------------------------------
// periodic_minimum_image_unit_core
// minimum image, displacement and folding for a triclinic periodic cell
// ----------------------------------------------------------------------------
// One item per cycle, unless the output stalls, through five register stages:
// the difference vector, the inverse matrix products, the sum with shift and
// wrap, the cell vector products, and the sum with offset and saturation.
// Stalls at the output back up stage by stage; bubbles in the pipeline are
// filled. Configuration writes are taken in every cycle and act at once on
// items in flight, so write them only while the pipeline is empty.
module periodic_minimum_image_unit_core #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  pmi_pkg::t_in                         i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output pmi_pkg::t_out                        o_out_data,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [pmi_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [pmi_pkg::CFG_W-1:0]            i_cfg_data
);

    localparam int NSTG = 5;

    logic                               r_cell;
    pmi_pkg::t_cfg_word                 r_axis [3];
    pmi_pkg::t_cfg_word                 r_inv [3];

    logic [NSTG-1:0]                    r_vld;
    logic [NSTG-1:0]                    n_vld;
    logic [NSTG-1:0]                    ld;

    logic signed [pmi_pkg::D_W-1:0]     r_d [4][3];
    logic signed [pmi_pkg::COORD_W-1:0] r_add [4][3];
    logic                               r_fold;

    logic signed [pmi_pkg::D_W-1:0]     n_d [3];
    logic signed [pmi_pkg::COORD_W-1:0] n_add [3];
    logic                               n_fold;
    logic signed [pmi_pkg::S_W-1:0]     s [3];

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_axis[i] <= '0;
                r_inv[i]  <= '0;
            end
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pmi_pkg::CFG_CELL_PRESENT: r_cell    <= i_cfg_data[0];
                pmi_pkg::CFG_AXIS_A:       r_axis[0] <= i_cfg_data;
                pmi_pkg::CFG_AXIS_B:       r_axis[1] <= i_cfg_data;
                pmi_pkg::CFG_AXIS_C:       r_axis[2] <= i_cfg_data;
                pmi_pkg::CFG_INV_ROW_X:    r_inv[0]  <= i_cfg_data;
                pmi_pkg::CFG_INV_ROW_Y:    r_inv[1]  <= i_cfg_data;
                pmi_pkg::CFG_INV_ROW_Z:    r_inv[2]  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline flow control
    always_comb begin
        ld[NSTG-1] = !r_vld[NSTG-1] || i_out_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            ld[k] = !r_vld[k] || ld[k+1];
        end
        n_vld[0] = ld[0] ? i_in_valid : r_vld[0];
        for (int k = 1; k < NSTG; k++) begin
            n_vld[k] = ld[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready  = ld[0];
    assign o_out_valid = r_vld[NSTG-1];

    // command decode and difference vector
    always_comb begin
        logic signed [pmi_pkg::D_W-1:0] r1 [3];
        logic signed [pmi_pkg::D_W-1:0] r2 [3];
        r1[0] = pmi_pkg::D_W'(i_in_data.first_x);
        r1[1] = pmi_pkg::D_W'(i_in_data.first_y);
        r1[2] = pmi_pkg::D_W'(i_in_data.first_z);
        r2[0] = pmi_pkg::D_W'(i_in_data.ref_x);
        r2[1] = pmi_pkg::D_W'(i_in_data.ref_y);
        r2[2] = pmi_pkg::D_W'(i_in_data.ref_z);
        unique case (i_in_data.command)
            pmi_pkg::CMD_FOLD: begin
                n_fold = 1'b1;
                for (int j = 0; j < 3; j++) begin
                    n_d[j]   = r1[j];
                    n_add[j] = '0;
                end
            end
            pmi_pkg::CMD_IMAGE_DISP: begin
                n_fold = 1'b0;
                for (int j = 0; j < 3; j++) begin
                    n_d[j]   = r1[j] - r2[j];
                    n_add[j] = '0;
                end
            end
            default: begin
                n_fold = 1'b0;
                for (int j = 0; j < 3; j++) begin
                    n_d[j]   = r1[j] - r2[j];
                    n_add[j] = r2[j][pmi_pkg::COORD_W-1:0];
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ld[0]) begin
            r_d[0]   <= n_d;
            r_add[0] <= n_add;
            r_fold   <= n_fold;
        end
        for (int k = 1; k < 4; k++) begin
            if (ld[k]) begin
                r_d[k]   <= r_d[k-1];
                r_add[k] <= r_add[k-1];
            end
        end
    end

    pmi_frac #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_frac (
        .i_clk  (i_clk),
        .i_adv  ({ld[1], ld[2]}),
        .i_d    (r_d[0]),
        .i_fold (r_fold),
        .i_inv  (r_inv),
        .o_s    (s)
    );

    pmi_back u_back (
        .i_clk  (i_clk),
        .i_adv  ({ld[3], ld[4]}),
        .i_s    (s),
        .i_axis (r_axis),
        .i_cell (r_cell),
        .i_d    (r_d[3]),
        .i_add  (r_add[3]),
        .o_out  (o_out_data)
    );

endmodule

[test/periodic_minimum_image_unit_core_tb.sv]
// ----------------------------------------------------------------------------
// periodic_minimum_image_unit_core_tb
// Drives pairs of positions through the periodic image unit under several
// cell settings (none, zero, cubic, skewed, extreme and arbitrary register
// words). A short table of directed items comes first, then random traffic
// with random gaps and stalls on both channels. Every result is compared with
// its table value or with a fixed-point predictor of the wrap arithmetic.
// ----------------------------------------------------------------------------
module periodic_minimum_image_unit_core_tb;

    localparam int FRAC_BITS = 16;
    localparam longint ONE_FRAC = longint'(1) << FRAC_BITS;
    localparam longint HALF_FRAC = longint'(1) << (FRAC_BITS - 1);
    localparam int UNIT = 65536;
    localparam int INT_MAX = 32'sh7FFF_FFFF;
    localparam int INT_MIN = 32'sh8000_0000;
    localparam int CUBE10 = 10240;
    localparam int INV10 = 52428;
    localparam int FIELD_MAX = 21'h0F_FFFF;
    localparam int FIELD_MIN = 21'h10_0000;
    localparam pmi_pkg::t_cmd CMD_UNUSED = pmi_pkg::t_cmd'(2'd3);

    typedef enum int {SET_RESET, SET_ZERO_CELL, SET_CUBE} t_cell_setup;

    typedef struct {
        t_cell_setup   setup;
        pmi_pkg::t_cmd cmd;
        int            r1x, r1y, r1z;
        int            r2x, r2y, r2z;
        bit            typed;
        int            ex, ey, ez;
    } t_dir_row;

    logic            i_clk = 1'b0;
    logic            i_rst_n;
    logic            i_in_valid;
    logic            o_in_ready;
    pmi_pkg::t_in    i_in_data;
    logic            o_out_valid;
    logic            i_out_ready;
    pmi_pkg::t_out   o_out_data;
    logic            i_cfg_valid;
    logic            o_cfg_ready;
    logic [pmi_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [pmi_pkg::CFG_W-1:0]     i_cfg_data;

    bit                 lattice_on;
    pmi_pkg::t_cfg_word lattice_axis [3];
    pmi_pkg::t_cfg_word lattice_inverse [3];

    pmi_pkg::t_out expected_images [$];
    int            failures = 0;
    int            near_span = 1 << 20;
    bit            quiet = 1'b0;
    bit            long_hold = 1'b0;
    int            hold_left = 0;

    periodic_minimum_image_unit_core #(
        .COORD_FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic longint coeff_of(input pmi_pkg::t_cfg_word word, input int k);
        logic signed [pmi_pkg::FIELD_W-1:0] f;
        f = word[pmi_pkg::FIELD_W*k +: pmi_pkg::FIELD_W];
        return f;
    endfunction

    function automatic logic signed [pmi_pkg::COORD_W-1:0] clamp32(input longint v);
        if (v > longint'(INT_MAX)) begin
            return INT_MAX;
        end
        if (v < longint'(INT_MIN)) begin
            return INT_MIN;
        end
        return v[pmi_pkg::COORD_W-1:0];
    endfunction

    function automatic pmi_pkg::t_out predict_image(input pmi_pkg::t_in it);
        longint        r1 [3];
        longint        r2 [3];
        longint        vec [3];
        longint        frac [3];
        longint        res [3];
        longint        acc;
        bit            fold;
        bit            disp;
        pmi_pkg::t_out o;
        r1[0] = longint'($signed(it.first_x));
        r1[1] = longint'($signed(it.first_y));
        r1[2] = longint'($signed(it.first_z));
        r2[0] = longint'($signed(it.ref_x));
        r2[1] = longint'($signed(it.ref_y));
        r2[2] = longint'($signed(it.ref_z));
        fold = (it.command == pmi_pkg::CMD_FOLD);
        disp = (it.command == pmi_pkg::CMD_IMAGE_DISP);
        for (int j = 0; j < 3; j++) begin
            vec[j] = fold ? r1[j] : r1[j] - r2[j];
        end
        if (!lattice_on) begin
            for (int j = 0; j < 3; j++) begin
                res[j] = disp ? vec[j] : r1[j];
            end
        end else begin
            for (int k = 0; k < 3; k++) begin
                acc = 0;
                for (int j = 0; j < 3; j++) begin
                    acc += vec[j] * coeff_of(lattice_inverse[j], k);
                end
                frac[k] = acc >>> pmi_pkg::INV_FRAC;
                if (fold) begin
                    if (frac[k] < 0) begin
                        frac[k] += ONE_FRAC;
                    end else if (frac[k] >= ONE_FRAC) begin
                        frac[k] -= ONE_FRAC;
                    end
                end else begin
                    if (frac[k] < -HALF_FRAC) begin
                        frac[k] += ONE_FRAC;
                    end
                    if (frac[k] > HALF_FRAC) begin
                        frac[k] -= ONE_FRAC;
                    end
                end
            end
            for (int j = 0; j < 3; j++) begin
                acc = 0;
                for (int k = 0; k < 3; k++) begin
                    acc += frac[k] * coeff_of(lattice_axis[k], j);
                end
                res[j] = acc >>> pmi_pkg::CELL_FRAC;
                if (!fold && !disp) begin
                    res[j] += r2[j];
                end
            end
        end
        o.out_x = clamp32(res[0]);
        o.out_y = clamp32(res[1]);
        o.out_z = clamp32(res[2]);
        return o;
    endfunction

    function automatic pmi_pkg::t_cfg_word pack3(input int fx, input int fy, input int fz);
        return {fz[pmi_pkg::FIELD_W-1:0], fy[pmi_pkg::FIELD_W-1:0],
                fx[pmi_pkg::FIELD_W-1:0]};
    endfunction

    function automatic pmi_pkg::t_cfg_word rand_word();
        return pmi_pkg::t_cfg_word'({$urandom, $urandom});
    endfunction

    function automatic real unit_rand();
        return real'($urandom) / 4294967296.0;
    endfunction

    function automatic int to_q10(input real v);
        return $rtoi(v * 1024.0);
    endfunction

    function automatic int to_q19(input real v);
        return $rtoi(v * 524288.0);
    endfunction

    function automatic logic signed [pmi_pkg::COORD_W-1:0] pick_coord(input int span);
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
            return int'($urandom_range(0, 2 * span)) - span;
        end
        if (sel < 85) begin
            return $urandom;
        end
        if (sel < 93) begin
            case ($urandom_range(0, 3))
                0: return INT_MAX;
                1: return INT_MIN;
                2: return 0;
                default: return -1;
            endcase
        end
        return int'($urandom_range(0, 1023)) - 512;
    endfunction

    function automatic pmi_pkg::t_in random_item(input int span);
        pmi_pkg::t_in it;
        int unsigned  sel;
        sel = $urandom_range(0, 99);
        if (sel < 32) begin
            it.command = pmi_pkg::CMD_IMAGE_POS;
        end else if (sel < 64) begin
            it.command = pmi_pkg::CMD_IMAGE_DISP;
        end else if (sel < 95) begin
            it.command = pmi_pkg::CMD_FOLD;
        end else begin
            it.command = CMD_UNUSED;
        end
        it.first_x = pick_coord(span);
        it.first_y = pick_coord(span);
        it.first_z = pick_coord(span);
        it.ref_x = pick_coord(span);
        it.ref_y = pick_coord(span);
        it.ref_z = pick_coord(span);
        return it;
    endfunction

    task automatic send_item(input pmi_pkg::t_in it, input bit typed,
                             input pmi_pkg::t_out typed_out);
        while (!quiet && $urandom_range(0, 99) < 14) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        expected_images.push_back(typed ? typed_out : predict_image(it));
    endtask

    task automatic stream_items(input int count);
        for (int n = 0; n < count; n++) begin
            send_item(random_item(near_span), 1'b0, '0);
        end
    endtask

    task automatic write_reg(input pmi_pkg::t_cfg_idx idx, input pmi_pkg::t_cfg_word val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        case (idx)
            pmi_pkg::CFG_CELL_PRESENT: lattice_on = val[0];
            pmi_pkg::CFG_AXIS_A: lattice_axis[0] = val;
            pmi_pkg::CFG_AXIS_B: lattice_axis[1] = val;
            pmi_pkg::CFG_AXIS_C: lattice_axis[2] = val;
            pmi_pkg::CFG_INV_ROW_X: lattice_inverse[0] = val;
            pmi_pkg::CFG_INV_ROW_Y: lattice_inverse[1] = val;
            pmi_pkg::CFG_INV_ROW_Z: lattice_inverse[2] = val;
            default: ;
        endcase
    endtask

    // drain the pipeline, then program all seven registers back to back
    task automatic load_lattice(input bit on, input pmi_pkg::t_cfg_word a,
                                input pmi_pkg::t_cfg_word b,
                                input pmi_pkg::t_cfg_word c,
                                input pmi_pkg::t_cfg_word ix,
                                input pmi_pkg::t_cfg_word iy,
                                input pmi_pkg::t_cfg_word iz);
        pmi_pkg::t_cfg_word flag_word;
        i_in_valid <= 1'b0;
        while (expected_images.size() != 0) begin
            @(posedge i_clk);
        end
        flag_word = rand_word();
        flag_word[0] = on;
        write_reg(pmi_pkg::CFG_AXIS_A, a);
        write_reg(pmi_pkg::CFG_AXIS_B, b);
        write_reg(pmi_pkg::CFG_AXIS_C, c);
        write_reg(pmi_pkg::CFG_INV_ROW_X, ix);
        write_reg(pmi_pkg::CFG_INV_ROW_Y, iy);
        write_reg(pmi_pkg::CFG_INV_ROW_Z, iz);
        write_reg(pmi_pkg::CFG_CELL_PRESENT, flag_word);
        i_cfg_valid <= 1'b0;
    endtask

    // upper-triangular cell with random lengths, optional tilt
    task automatic build_lattice(input real lo, input real hi, input bit skew);
        real ax, by, cz, bx, cx, cy;
        ax = lo + (hi - lo) * unit_rand();
        by = lo + (hi - lo) * unit_rand();
        cz = lo + (hi - lo) * unit_rand();
        bx = skew ? (unit_rand() - 0.5) * ax : 0.0;
        cx = skew ? (unit_rand() - 0.5) * ax : 0.0;
        cy = skew ? (unit_rand() - 0.5) * by : 0.0;
        near_span = $rtoi((ax + by + cz) * 65536.0);
        load_lattice(1'b1,
                     pack3(to_q10(ax), 0, 0),
                     pack3(to_q10(bx), to_q10(by), 0),
                     pack3(to_q10(cx), to_q10(cy), to_q10(cz)),
                     pack3(to_q19(1.0 / ax), 0, 0),
                     pack3(to_q19(-bx / (ax * by)), to_q19(1.0 / by), 0),
                     pack3(to_q19((bx * cy - cx * by) / (ax * by * cz)),
                           to_q19(-cy / (by * cz)), to_q19(1.0 / cz)));
    endtask

    task automatic check_image(input pmi_pkg::t_out got);
        pmi_pkg::t_out want;
        if (expected_images.size() == 0) begin
            $error("result transfer with no expected result");
            failures++;
        end else begin
            want = expected_images.pop_front();
            if (got.out_x !== want.out_x) begin
                $error("out_x expected %0d actual %0d", want.out_x, got.out_x);
                failures++;
            end
            if (got.out_y !== want.out_y) begin
                $error("out_y expected %0d actual %0d", want.out_y, got.out_y);
                failures++;
            end
            if (got.out_z !== want.out_z) begin
                $error("out_z expected %0d actual %0d", want.out_z, got.out_z);
                failures++;
            end
        end
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                check_image(o_out_data);
            end
            if (long_hold) begin
                long_hold = 1'b0;
                hold_left = 120;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= quiet || ($urandom_range(0, 99) >= 14);
            end
        end
    end

    initial begin
        #400000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        t_dir_row      steps [21];
        t_cell_setup   cur;
        pmi_pkg::t_in  it;
        pmi_pkg::t_out typed_out;
        steps = '{
            '{SET_RESET, pmi_pkg::CMD_IMAGE_POS, INT_MAX, INT_MIN, 0, 1, 2, 3,
              1'b1, INT_MAX, INT_MIN, 0},
            '{SET_RESET, pmi_pkg::CMD_IMAGE_DISP, INT_MAX, INT_MIN, 0, INT_MIN, INT_MAX, 0,
              1'b1, INT_MAX, INT_MIN, 0},
            '{SET_RESET, pmi_pkg::CMD_IMAGE_DISP, 5, -5, UNIT, 2, 3, -UNIT,
              1'b1, 3, -8, 2 * UNIT},
            '{SET_RESET, pmi_pkg::CMD_FOLD, -1, INT_MAX, INT_MIN, 9, 9, 9,
              1'b1, -1, INT_MAX, INT_MIN},
            '{SET_RESET, CMD_UNUSED, 7, 8, 9, 100, 100, 100,
              1'b1, 7, 8, 9},
            '{SET_ZERO_CELL, pmi_pkg::CMD_IMAGE_POS, INT_MAX, INT_MIN, 123, -5, 6, INT_MAX,
              1'b1, -5, 6, INT_MAX},
            '{SET_ZERO_CELL, pmi_pkg::CMD_IMAGE_DISP, INT_MAX, INT_MIN, 123, -5, 6, INT_MAX,
              1'b1, 0, 0, 0},
            '{SET_ZERO_CELL, pmi_pkg::CMD_FOLD, INT_MAX, INT_MIN, 123, -5, 6, INT_MAX,
              1'b1, 0, 0, 0},
            '{SET_ZERO_CELL, CMD_UNUSED, 1, 2, 3, -4, -5, -6,
              1'b1, -4, -5, -6},
            '{SET_CUBE, pmi_pkg::CMD_IMAGE_DISP, 6 * UNIT, 0, 0, 0, 0, 0,
              1'b0, 0, 0, 0},
            '{SET_CUBE, pmi_pkg::CMD_IMAGE_DISP, -6 * UNIT, 4 * UNIT, 0, 0, 0, 0,
              1'b0, 0, 0, 0},
            '{SET_CUBE, pmi_pkg::CMD_IMAGE_POS, 9 * UNIT + UNIT / 2, 9 * UNIT, -9 * UNIT,
              UNIT / 2, UNIT / 2, UNIT / 2, 1'b0, 0, 0, 0},
            '{SET_CUBE, pmi_pkg::CMD_FOLD, -3 * UNIT, 12 * UNIT, 25 * UNIT, 0, 0, 0,
              1'b0, 0, 0, 0},
            '{SET_CUBE, pmi_pkg::CMD_FOLD, 0, 0, 0, 1, 1, 1, 1'b0, 0, 0, 0},
            '{SET_CUBE, pmi_pkg::CMD_FOLD, 10 * UNIT, 10 * UNIT, 10 * UNIT, 0, 0, 0,
              1'b0, 0, 0, 0},
            '{SET_CUBE, pmi_pkg::CMD_IMAGE_DISP, INT_MAX, INT_MAX, INT_MAX, INT_MIN,
              INT_MIN, INT_MIN, 1'b0, 0, 0, 0},
            '{SET_CUBE, pmi_pkg::CMD_IMAGE_POS, 5 * UNIT, -5 * UNIT, 0, 0, 0, 0,
              1'b0, 0, 0, 0},
            '{SET_CUBE, CMD_UNUSED, 7 * UNIT, -7 * UNIT, 3 * UNIT, UNIT, UNIT, UNIT,
              1'b0, 0, 0, 0},
            '{SET_CUBE, pmi_pkg::CMD_IMAGE_POS, INT_MIN, INT_MIN, INT_MIN, INT_MAX,
              INT_MAX, INT_MAX, 1'b0, 0, 0, 0},
            '{SET_CUBE, pmi_pkg::CMD_IMAGE_DISP, 15 * UNIT, -15 * UNIT, 2 * UNIT, 0, 0, 0,
              1'b0, 0, 0, 0},
            '{SET_CUBE, pmi_pkg::CMD_IMAGE_DISP, 25 * UNIT, -25 * UNIT, -5 * UNIT, 0, 0, 0,
              1'b0, 0, 0, 0}
        };
        lattice_on = 1'b0;
        for (int k = 0; k < 3; k++) begin
            lattice_axis[k] = '0;
            lattice_inverse[k] = '0;
        end
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= pmi_pkg::CFG_CELL_PRESENT;
        i_cfg_data <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        cur = SET_RESET;
        foreach (steps[i]) begin
            if (steps[i].setup != cur) begin
                cur = steps[i].setup;
                if (cur == SET_ZERO_CELL) begin
                    load_lattice(1'b1, '0, '0, '0, '0, '0, '0);
                end else begin
                    load_lattice(1'b1, pack3(CUBE10, 0, 0), pack3(0, CUBE10, 0),
                                 pack3(0, 0, CUBE10), pack3(INV10, 0, 0),
                                 pack3(0, INV10, 0), pack3(0, 0, INV10));
                end
            end
            it.command = steps[i].cmd;
            it.first_x = steps[i].r1x;
            it.first_y = steps[i].r1y;
            it.first_z = steps[i].r1z;
            it.ref_x = steps[i].r2x;
            it.ref_y = steps[i].r2y;
            it.ref_z = steps[i].r2z;
            typed_out.out_x = steps[i].ex;
            typed_out.out_y = steps[i].ey;
            typed_out.out_z = steps[i].ez;
            send_item(it, steps[i].typed, typed_out);
        end

        build_lattice(3.0, 40.0, 1'b0);
        stream_items(80);
        long_hold = 1'b1;
        stream_items(80);

        build_lattice(2.0, 30.0, 1'b1);
        quiet = 1'b1;
        stream_items(120);
        quiet = 1'b0;

        build_lattice(300.0, 1000.0, 1'b1);
        stream_items(120);

        build_lattice(1.0, 2.0, 1'b1);
        stream_items(120);

        near_span = 1 << 28;
        load_lattice(1'b1, pack3(FIELD_MAX, FIELD_MAX, FIELD_MAX),
                     pack3(FIELD_MAX, FIELD_MAX, FIELD_MAX),
                     pack3(FIELD_MAX, FIELD_MAX, FIELD_MAX),
                     pack3(FIELD_MAX, FIELD_MAX, FIELD_MAX),
                     pack3(FIELD_MAX, FIELD_MAX, FIELD_MAX),
                     pack3(FIELD_MAX, FIELD_MAX, FIELD_MAX));
        stream_items(100);

        load_lattice(1'b1, pack3(FIELD_MIN, FIELD_MIN, FIELD_MIN),
                     pack3(FIELD_MIN, FIELD_MIN, FIELD_MIN),
                     pack3(FIELD_MIN, FIELD_MIN, FIELD_MIN),
                     pack3(FIELD_MIN, FIELD_MIN, FIELD_MIN),
                     pack3(FIELD_MIN, FIELD_MIN, FIELD_MIN),
                     pack3(FIELD_MIN, FIELD_MIN, FIELD_MIN));
        stream_items(100);

        load_lattice(1'b1, '1, '1, '1, '1, '1, '1);
        stream_items(100);

        near_span = 1 << 20;
        load_lattice(1'b1, rand_word(), rand_word(), rand_word(),
                     rand_word(), rand_word(), rand_word());
        stream_items(100);

        load_lattice(1'b0, rand_word(), rand_word(), rand_word(),
                     rand_word(), rand_word(), rand_word());
        stream_items(100);

        build_lattice(5.0, 60.0, 1'b1);
        stream_items(80);

        i_in_valid <= 1'b0;
        while (expected_images.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        if (failures == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[files.f]
src/pmi_pkg.sv
src/pmi_frac.sv
src/pmi_back.sv
src/periodic_minimum_image_unit_core.sv
test/periodic_minimum_image_unit_core_tb.sv
